// ===== rtl/mbi_pkg.sv =====
// Shared types and constants for the MurmurHash2 bucket index block.
// No dependencies; used by mbi_ctrl, mbi_dp and murmur2_bucket_index.
`default_nettype none

package mbi_pkg;

  localparam logic [31:0] MixMul      = 32'h5bd1e995;
  localparam int          MixShift    = 24;
  localparam int          FinShiftA   = 13;
  localparam int          FinShiftB   = 15;
  localparam logic [31:0] HashSeed    = 32'd0;

  localparam int          BucketWidth = 21;
  localparam int          IndexWidth  = 20;
  localparam logic [BucketWidth-1:0] MaxBuckets  = BucketWidth'(1048576);
  localparam logic [BucketWidth-1:0] BucketReset = BucketWidth'(1024);

  localparam int          DivSteps    = 32;
  localparam int          CntWidth    = $clog2(DivSteps);

  // one datapath step per cycle, chosen by the controller
  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_LOAD,
    STEP_MK1,
    STEP_MK2,
    STEP_MH,
    STEP_TAIL,
    STEP_FIN,
    STEP_DIV
  } step_t;

  typedef struct packed {
    step_t step;
    logic  out_load;
  } cmd_t;

  // keep only the valid low bytes of a short word
  function automatic logic [31:0] byte_mask(input logic [2:0] nbytes);
    logic [31:0] m;
    unique case (nbytes)
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mbi_ctrl.sv =====
// Controller for the MurmurHash2 bucket index block: sequences the datapath.
// Depends on mbi_pkg for the command struct and divider constants.
`default_nettype none

module mbi_ctrl
  import mbi_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_nbytes,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output cmd_t            cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MK1  = 8'b0000_0010,
    S_MK2  = 8'b0000_0100,
    S_MH   = 8'b0000_1000,
    S_TAIL = 8'b0001_0000,
    S_FIN  = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t              state, state_next;
  logic                last_flag, last_flag_next;
  logic [CntWidth-1:0] cnt, cnt_next;
  logic                out_full, out_full_next;
  logic                accept;
  logic                full_word, tail_word;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_full;
  // byte counts of four and above count as a full word
  assign full_word = in_nbytes[2];
  assign tail_word = !in_nbytes[2] && (in_nbytes != 3'd0);

  always_comb begin
    state_next     = state;
    last_flag_next = last_flag;
    cnt_next       = cnt;
    out_full_next  = out_full && !out_ready;
    cmd.step       = STEP_NONE;
    cmd.out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.step       = STEP_LOAD;
          last_flag_next = in_last;
          if (full_word) begin
            state_next = S_MK1;
          end else if (tail_word) begin
            state_next = S_TAIL;
          end else if (in_last) begin
            state_next = S_FIN;
          end
        end
      end
      S_MK1: begin
        cmd.step   = STEP_MK1;
        state_next = S_MK2;
      end
      S_MK2: begin
        cmd.step   = STEP_MK2;
        state_next = S_MH;
      end
      S_MH: begin
        cmd.step   = STEP_MH;
        state_next = last_flag ? S_FIN : S_IDLE;
      end
      S_TAIL: begin
        cmd.step   = STEP_TAIL;
        state_next = last_flag ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        cmd.step   = STEP_FIN;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.step = STEP_DIV;
        cnt_next = cnt + 1'b1;
        if (cnt == CntWidth'(DivSteps - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free or being drained
        if (!out_full || out_ready) begin
          cmd.out_load  = 1'b1;
          out_full_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_flag <= 1'b0;
      cnt       <= '0;
      out_full  <= 1'b0;
    end else begin
      state     <= state_next;
      last_flag <= last_flag_next;
      cnt       <= cnt_next;
      out_full  <= out_full_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mbi_dp.sv =====
// Datapath for the MurmurHash2 bucket index block: shared multiplier,
// running hash, bit-serial divider and result register. Depends on mbi_pkg.
`default_nettype none

module mbi_dp
  import mbi_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cmd_t                   cmd,
  input  wire logic [31:0]            in_word,
  input  wire logic [2:0]             in_nbytes,
  input  wire logic [31:0]            in_total,
  input  wire logic                   in_first,
  input  wire logic                   cfg_we,
  input  wire logic [BucketWidth-1:0] cfg_data,
  output logic [31:0]                 hash_value,
  output logic [IndexWidth-1:0]       bucket_index
);

  logic [BucketWidth-1:0] bucket_count;
  logic [BucketWidth-1:0] bc_eff;
  logic [BucketWidth-1:0] divisor;
  logic                   div_zero;
  logic [31:0]            hreg;
  logic [31:0]            kreg;
  logic [31:0]            freg;
  logic [31:0]            dvd;
  logic [IndexWidth-1:0]  rem;
  logic [31:0]            mul_a;
  logic [31:0]            product;
  logic [31:0]            fin_val;
  logic [IndexWidth:0]    rem_shift;
  logic [IndexWidth:0]    rem_sub;
  logic                   rem_ge;

  always_comb begin
    unique case (cmd.step)
      STEP_MK2:  mul_a = kreg ^ (kreg >> MixShift);
      STEP_MH:   mul_a = hreg;
      STEP_TAIL: mul_a = hreg ^ kreg;
      STEP_FIN:  mul_a = hreg ^ (hreg >> FinShiftA);
      default:   mul_a = kreg;
    endcase
  end

  assign product = mul_a * MixMul;
  assign fin_val = product ^ (product >> FinShiftB);

  assign bc_eff    = (bucket_count > MaxBuckets) ? MaxBuckets : bucket_count;
  assign rem_shift = {rem, dvd[31]};
  assign rem_ge    = (rem_shift >= divisor);
  assign rem_sub   = rem_shift - divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BucketReset;
      hreg         <= '0;
    end else begin
      if (cfg_we) begin
        bucket_count <= cfg_data;
      end
      if (cmd.step == STEP_LOAD) begin
        hreg <= in_first ? (HashSeed ^ in_total) : hreg;
      end else if (cmd.step == STEP_MH) begin
        hreg <= product ^ kreg;
      end else if (cmd.step == STEP_TAIL) begin
        hreg <= product;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.step)
      STEP_LOAD: begin
        kreg <= in_word & byte_mask(in_nbytes);
      end
      STEP_MK1, STEP_MK2: begin
        kreg <= product;
      end
      STEP_FIN: begin
        freg     <= fin_val;
        dvd      <= fin_val;
        rem      <= '0;
        divisor  <= bc_eff;
        div_zero <= (bc_eff == '0);
      end
      STEP_DIV: begin
        dvd <= {dvd[30:0], 1'b0};
        rem <= rem_ge ? rem_sub[IndexWidth-1:0] : rem_shift[IndexWidth-1:0];
      end
      default: begin
      end
    endcase
    if (cmd.out_load) begin
      hash_value   <= freg;
      bucket_index <= div_zero ? '0 : rem;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/murmur2_bucket_index.sv =====
// Top level: MurmurHash2 (seed 0) of a byte string reduced to a bucket index.
// Instantiates mbi_ctrl and mbi_dp; depends on mbi_pkg.
//
//   channel   direction  handshake             payload
//   s_*       in         s_tvalid / s_tready   s_tdata, s_tlast, s_tuser
//   m_*       out        m_tvalid / m_tready   m_tdata
//   cfg_*     in         cfg_valid / cfg_ready cfg_data (bucket_count)
//
// Sequence: a four-byte word is accepted and then makes three passes through
// the one shared 32x32 multiplier, a one-to-three byte word a tail pass through
// it, an empty word no pass. A last word then adds a finalise pass, a run of the
// bit-serial divider and a load of the output register.
// Reset: synchronous rst clears the sequencer, the running hash and sets the
// bucket count to 1024. Stalls: the output register holds a result while the
// next words are accepted; a second result waits in place until m_tready.
`default_nettype none

module murmur2_bucket_index
  import mbi_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // stream in
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [71:0]            s_tdata,  // data_word[31:0], byte_count[34:32],
                                                // total_length[66:35], zero pad [71:67]
  input  wire logic                   s_tlast,  // last_item
  input  wire logic                   s_tuser,  // first_item
  // stream out
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [55:0]                 m_tdata,  // hash_value[31:0], bucket_index[51:32],
                                                // zero pad [55:52]
  // bucket count register write
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [BucketWidth-1:0] cfg_data
);

  cmd_t                  cmd;
  logic [31:0]           hash_value;
  logic [IndexWidth-1:0] bucket_index;
  logic                  cfg_we;

  // writes must only arrive while idle (the block does not enforce this), so take every beat at once
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  mbi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_nbytes (s_tdata[34:32]),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  mbi_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_word      (s_tdata[31:0]),
    .in_nbytes    (s_tdata[34:32]),
    .in_total     (s_tdata[66:35]),
    .in_first     (s_tuser),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .hash_value   (hash_value),
    .bucket_index (bucket_index)
  );

  // pack the result beat, lowest field first, padded to whole bytes
  assign m_tdata = {4'd0, bucket_index, hash_value};

endmodule

`default_nettype wire
